// File: rtl/core/fdt_pkg.sv
// Shared types and constants for the fixed-point to decimal text unit.
package fdt_pkg;

  // Field widths
  localparam int VALUE_W    = 48;  // signed fixed-point input
  localparam int BIN_W      = 32;  // clamped scaled magnitude
  localparam int SCALE_W    = 30;  // bits of the largest power of ten (10^9)
  localparam int PROD_W     = VALUE_W + SCALE_W;
  localparam int MAX_DIGITS = 10;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int DP_W       = 4;   // decimal places register
  localparam int LEN_W      = 4;   // text length
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = $clog2(BIN_W);
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  // Defaults
  localparam int                FRAC_BITS_DEF = 16;
  localparam logic [DP_W-1:0]   DP_RESET      = 4'd2;
  localparam logic [DP_W-1:0]   DP_MAX        = 4'd9;

  // Characters
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2E;

  // Kind of character placed in the output register
  typedef enum logic [1:0] {
    CHAR_SIGN,
    CHAR_DIGIT,
    CHAR_POINT
  } fdt_char_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;        // take input value, latch sign and places
    logic             scale_step;  // product times ten
    logic             conv_load;   // clamp product, start binary to BCD
    logic             conv_step;   // one shift-add-3 step
    logic             size_latch;  // register text length
    logic             emit;        // load output register
    fdt_char_kind_t   kind;
    logic [IDX_W-1:0] digit_idx;
    logic             last;
  } fdt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             neg;
    logic [DP_W-1:0]  dec_places;  // latched, clamped to nine
    logic [LEN_W-1:0] n_digits;    // digits to print
    logic             out_free;    // output register can take a character
  } fdt_sts_t;

endpackage

// File: rtl/core/fdt_datapath.sv
// Datapath: config register, power-of-ten scaling, binary to BCD, output register.
module fdt_datapath #(
  parameter int FRAC_BITS = fdt_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [fdt_pkg::DP_W-1:0]     cfg_wr_data,
  input  logic [fdt_pkg::VALUE_W-1:0]  in_value,
  input  fdt_pkg::fdt_cmd_t            cmd,
  output fdt_pkg::fdt_sts_t            sts,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [fdt_pkg::CHAR_W-1:0]   out_char,
  output logic [fdt_pkg::LEN_W-1:0]    out_len,
  output logic                         out_last,
  output logic                         out_sat
);
  import fdt_pkg::*;

  logic [DP_W-1:0]                 dp_cfg_r;
  logic [DP_W-1:0]                 dp_r;
  logic                            neg_r;
  logic [PROD_W-1:0]               prod_r;
  logic [BIN_W-1:0]                bin_r;
  logic [MAX_DIGITS-1:0][3:0]      bcd_r;
  logic                            sat_r;
  logic [LEN_W-1:0]                len_r;
  logic                            out_tvalid_r;
  logic [CHAR_W-1:0]               out_char_r;
  logic [LEN_W-1:0]                out_len_r;
  logic                            out_last_r;
  logic                            out_sat_r;

  logic [VALUE_W-1:0]              mag;
  logic [PROD_W-1:0]               shifted;
  logic                            sat_now;
  logic [MAX_DIGITS-1:0][3:0]      bcd_adj;
  logic [BCD_W-1:0]                bcd_flat;
  logic [LEN_W-1:0]                sig_digits;
  logic [LEN_W-1:0]                n_digits;
  logic [LEN_W-1:0]                text_len;
  logic [CHAR_W-1:0]               char_sel;

  // Magnitude of the input; the most negative value maps to 2^47 exactly
  assign mag = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;

  // Drop the fraction bits and check the 32-bit range
  assign shifted = prod_r >> FRAC_BITS;
  assign sat_now = |shifted[PROD_W-1:BIN_W];

  // Add-3 correction for each BCD digit
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end
  assign bcd_flat = bcd_adj;

  // Significant digits, at least one
  always_comb begin
    sig_digits = LEN_W'(1);
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) sig_digits = LEN_W'(i + 1);
    end
  end

  // At least places+1 digits; sign and point add to the length
  always_comb begin
    n_digits = (sig_digits > (LEN_W'(dp_r) + LEN_W'(1))) ?
               sig_digits : (LEN_W'(dp_r) + LEN_W'(1));
    text_len = n_digits + LEN_W'(neg_r) + LEN_W'(dp_r != '0);
  end

  // Character for the output register
  always_comb begin
    case (cmd.kind)
      CHAR_SIGN:  char_sel = ASCII_MINUS;
      CHAR_POINT: char_sel = ASCII_POINT;
      default:    char_sel = ASCII_ZERO + CHAR_W'(bcd_r[cmd.digit_idx]);
    endcase
  end

  // Config register and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_cfg_r     <= DP_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) dp_cfg_r <= cfg_wr_data;
      if (cmd.emit) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= in_value[VALUE_W-1];
      dp_r   <= (dp_cfg_r > DP_MAX) ? DP_MAX : dp_cfg_r;
      prod_r <= PROD_W'(mag);
    end
    if (cmd.scale_step) prod_r <= (prod_r << 3) + (prod_r << 1);
    if (cmd.conv_load) begin
      sat_r <= sat_now;
      bin_r <= sat_now ? '1 : shifted[BIN_W-1:0];
      bcd_r <= '0;
    end
    if (cmd.conv_step) begin
      bcd_r <= {bcd_flat[BCD_W-2:0], bin_r[BIN_W-1]};
      bin_r <= {bin_r[BIN_W-2:0], 1'b0};
    end
    if (cmd.size_latch) len_r <= text_len;
    if (cmd.emit) begin
      out_char_r <= char_sel;
      out_len_r  <= len_r;
      out_last_r <= cmd.last;
      out_sat_r  <= sat_r;
    end
  end

  assign sts.neg        = neg_r;
  assign sts.dec_places = dp_r;
  assign sts.n_digits   = n_digits;
  assign sts.out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_char   = out_char_r;
  assign out_len    = out_len_r;
  assign out_last   = out_last_r;
  assign out_sat    = out_sat_r;

endmodule

// File: rtl/core/fdt_controller.sv
// Controller: sequences scaling, conversion and character emission.
module fdt_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  fdt_pkg::fdt_sts_t  sts,
  output fdt_pkg::fdt_cmd_t  cmd
);
  import fdt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_CONV,
    S_SIZE,
    S_SIGN,
    S_DIGIT,
    S_POINT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] idx_r;

  logic scale_done;
  logic conv_done;
  logic point_next;

  assign scale_done = (cnt_r == CNT_W'(sts.dec_places));
  assign conv_done  = (cnt_r == CNT_W'(BIN_W - 1));
  assign point_next = (sts.dec_places != '0) && (IDX_W'(sts.dec_places) == idx_r);

  // No transaction is taken while reset is held
  assign in_tready = rst_n && (state_r == S_IDLE);

  // Commands decoded from state
  always_comb begin
    cmd            = '0;
    cmd.kind       = CHAR_DIGIT;
    cmd.digit_idx  = idx_r;
    cmd.last       = (state_r == S_DIGIT) && (idx_r == '0);
    unique case (state_r)
      S_IDLE:  cmd.load       = in_tvalid;
      S_SCALE: begin
        cmd.scale_step = !scale_done;
        cmd.conv_load  = scale_done;
      end
      S_CONV:  cmd.conv_step  = 1'b1;
      S_SIZE:  cmd.size_latch = 1'b1;
      S_SIGN: begin
        cmd.kind = CHAR_SIGN;
        cmd.emit = sts.out_free;
      end
      S_DIGIT: cmd.emit = sts.out_free;
      S_POINT: begin
        cmd.kind = CHAR_POINT;
        cmd.emit = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_tvalid) state_r <= S_SCALE;
        end
        S_SCALE: begin
          if (scale_done) begin
            cnt_r   <= '0;
            state_r <= S_CONV;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_CONV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (conv_done) state_r <= S_SIZE;
        end
        S_SIZE: begin
          idx_r   <= IDX_W'(sts.n_digits - LEN_W'(1));
          state_r <= sts.neg ? S_SIGN : S_DIGIT;
        end
        S_SIGN: begin
          if (sts.out_free) state_r <= S_DIGIT;
        end
        S_DIGIT: begin
          if (sts.out_free) begin
            if (idx_r == '0) state_r <= S_IDLE;
            else if (point_next) state_r <= S_POINT;
            if (idx_r != '0) idx_r <= idx_r - IDX_W'(1);
          end
        end
        S_POINT: begin
          if (sts.out_free) state_r <= S_DIGIT;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/fixed_to_decimal_text_unit.sv
// Top level: signed fixed-point value in, decimal ASCII text out, one character per transaction.
//
// Input channel: one transaction carries a 48-bit two's complement value with
// FRAC_BITS fraction bits. Output channel: one transaction per character,
// most significant first: optional '-', digits, and a '.' before the last
// decimal_places digits. tlast marks the final character; every character
// carries the text length and the saturation flag.
// decimal_places must be written through cfg_wr_en/cfg_wr_data only while idle; the unit
// does not enforce this. Values above nine act as nine. Reset sets it to two and empties the unit.
// Steps per value: accept it, scale the 78-bit product by ten once per decimal
// place, clamp it, run the shift-add-3 binary to BCD conversion over every bit
// of the clamped 32-bit value, size the text, then emit one character per cycle
// while the receiver is ready. A new value is accepted once the last character
// is in the output register.
// When the receiver stalls, the output register holds its character and the
// sequencer waits; nothing is dropped.
module fixed_to_decimal_text_unit #(
  parameter int FRAC_BITS = fdt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [fdt_pkg::DP_W-1:0]      cfg_wr_data,  // decimal_places
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [fdt_pkg::VALUE_W-1:0]   in_tdata,     // [47:0] value
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,    // [7:0] char_code, [11:8] text_length
  output logic                          out_tlast,    // last
  output logic [0:0]                    out_tuser     // [0] saturated
);
  import fdt_pkg::*;

  fdt_cmd_t          cmd;
  fdt_sts_t          sts;
  logic [CHAR_W-1:0] out_char;
  logic [LEN_W-1:0]  out_len;
  logic              out_sat;

  fdt_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_value    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_char    (out_char),
    .out_len     (out_len),
    .out_last    (out_tlast),
    .out_sat     (out_sat)
  );

  fdt_controller u_controller (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Pack result fields, zero-filled to whole bytes
  assign out_tdata = {4'b0000, out_len, out_char};
  assign out_tuser = out_sat;

endmodule
